[hdl/trend_pattern_matcher_top_defines.svh]
// ----------------------------------------------------------------------------
// trend_pattern_matcher_top_defines
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef TREND_PATTERN_MATCHER_TOP_DEFINES_SVH
`define TREND_PATTERN_MATCHER_TOP_DEFINES_SVH

// same-cycle implication
`define TPM_ASSERT_IMP(label, clk_sig, rstn_sig, ante, cons) \
label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
    else $error("tpm check failed");

// next-cycle implication
`define TPM_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
    else $error("tpm check failed");

`endif

[hdl/tpm_pkg.sv]
// ----------------------------------------------------------------------------
// tpm_pkg
// shared types, codes and helpers of the trend pattern matcher
// ----------------------------------------------------------------------------
`default_nettype none

package tpm_pkg;

    localparam logic [1:0] STEP_EQUAL = 2'd0;
    localparam logic [1:0] STEP_RISE  = 2'd1;
    localparam logic [1:0] STEP_FALL  = 2'd2;
    localparam logic [1:0] STEP_FALL2 = 2'd3;

    localparam int CODE_STEPS = 16;
    localparam int PADDR_W    = 3;

    localparam logic REG_PATTERN_LENGTH = 1'b0;
    localparam logic REG_PATTERN_CODE   = 1'b1;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    function automatic logic [1:0] norm_step(input logic [1:0] code);
        logic [1:0] res;
        res = (code == STEP_FALL2) ? STEP_FALL : code;
        return res;
    endfunction

endpackage

`default_nettype wire

[hdl/tpm_cell.sv]
// ----------------------------------------------------------------------------
// tpm_cell
// one history position: holds a step class and compares it to its pattern step
// ----------------------------------------------------------------------------
`default_nettype none

module tpm_cell
    import tpm_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int LEN_W = 5
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [1:0]       step_in,
    input  wire logic             valid_in,
    input  wire logic [LEN_W-1:0] len_eff,
    input  wire logic [31:0]      pattern_code,
    output logic [1:0]            step_out,
    output logic                  valid_out,
    output logic                  hit
);

    logic [1:0] step_reg;
    logic       valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_EQUAL;
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            step_reg  <= STEP_EQUAL;
            valid_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            step_reg  <= step_in;
            valid_reg <= valid_in;
        end
    end

    always_comb
    begin
        int         j;
        logic       active;
        logic [1:0] want;
        active = (32'(IDX) < 32'(len_eff));
        j      = int'(len_eff) - 1 - IDX;
        want   = STEP_EQUAL;
        for (int k = 0; k < CODE_STEPS; k++)
        begin
            if (j == k)
            begin
                want = norm_step(pattern_code[2*k +: 2]);
            end
        end
        hit = !active || (valid_reg && (step_reg == want));
    end

    assign step_out  = step_reg;
    assign valid_out = valid_reg;

endmodule

`default_nettype wire

[hdl/trend_pattern_matcher_top.sv]
// path: an accepted item passes the pending stage, then the output register
// throughput: 1 item per cycle unless m_axis_tready stalls, set by the shift
// of the cell row and a single pending stage ahead of the output register
// reset: rst_n async low clears history, count, valid flags and registers
// (pattern_length 1, pattern_code 0); no clearing pass
// ----------------------------------------------------------------------------
// trend_pattern_matcher_top
// classifies sample steps into a row of cells and counts pattern matches
// ----------------------------------------------------------------------------
`default_nettype none

module trend_pattern_matcher_top
    import tpm_pkg::*;
#(
    parameter int MAX_PATTERN = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // apb configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input items
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [31:0]        s_axis_tdata,   // [31:0] sample
    input  wire logic               s_axis_tuser,   // [0] sequence_start
    // result items
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [31:0]             m_axis_tdata,   // [31:0] match_count
    output logic                    m_axis_tuser    // [0] window_match
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic [4:0]       pattern_length_reg;
    logic [31:0]      pattern_code_reg;
    logic             cfg_wr;

    logic [31:0]      prev_reg;
    logic             have_prev_reg;
    logic             p_valid_reg;
    logic             p_start_reg;
    logic [31:0]      count_reg;
    logic [31:0]      count_next;
    logic [31:0]      count_base;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_match_reg;
    logic [31:0]      out_count_reg;

    logic             in_accept;
    logic             advance;
    logic [1:0]       new_step;
    logic             match;
    logic [LEN_W-1:0] len_eff;
    cell_ctrl_t       cell_ctrl;

    logic [1:0]             step_chain  [MAX_PATTERN];
    logic                   valid_chain [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hit_vec;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= 5'd1;
            pattern_code_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[PADDR_W-1])
                REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[4:0];
                REG_PATTERN_CODE:   pattern_code_reg   <= pwdata;
                default:            pattern_code_reg   <= pattern_code_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[PADDR_W-1])
            REG_PATTERN_LENGTH: prdata = {27'd0, pattern_length_reg};
            REG_PATTERN_CODE:   prdata = pattern_code_reg;
            default:            prdata = '0;
        endcase
    end

    assign len_eff = (32'(pattern_length_reg) > 32'(MAX_PATTERN)) ?
                     LEN_W'(MAX_PATTERN) : LEN_W'(pattern_length_reg);

    // handshake
    assign advance       = p_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !p_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // step class of the incoming sample
    always_comb
    begin
        if ($signed(s_axis_tdata) > $signed(prev_reg))
        begin
            new_step = STEP_RISE;
        end
        else if (s_axis_tdata == prev_reg)
        begin
            new_step = STEP_EQUAL;
        end
        else
        begin
            new_step = STEP_FALL;
        end
    end

    assign cell_ctrl.clear = in_accept && s_axis_tuser;
    assign cell_ctrl.shift = in_accept && !s_axis_tuser && have_prev_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            prev_reg <= s_axis_tdata;
        end
    end

    // cell row, position 0 is the newest step
    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        logic [1:0] step_link;
        logic       valid_link;
        if (i == 0)
        begin : g_head
            assign step_link  = new_step;
            assign valid_link = 1'b1;
        end
        else
        begin : g_body
            assign step_link  = step_chain[i-1];
            assign valid_link = valid_chain[i-1];
        end
        tpm_cell #(
            .IDX   (i),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (cell_ctrl),
            .step_in      (step_link),
            .valid_in     (valid_link),
            .len_eff      (len_eff),
            .pattern_code (pattern_code_reg),
            .step_out     (step_chain[i]),
            .valid_out    (valid_chain[i]),
            .hit          (hit_vec[i])
        );
    end

    assign match = &hit_vec;

    // saturating count
    assign count_base = p_start_reg ? '0 : count_reg;
    assign count_next = (match && (count_base != '1)) ? count_base + 32'd1 : count_base;

    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            p_valid_reg   <= 1'b0;
            p_start_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                have_prev_reg <= 1'b1;
                p_valid_reg   <= 1'b1;
                p_start_reg   <= s_axis_tuser;
            end
            else if (advance)
            begin
                p_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_match_reg <= match;
            out_count_reg <= count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_count_reg;
    assign m_axis_tuser  = out_match_reg;

endmodule

`default_nettype wire

[hdl/tpm_checker.sv]
// ----------------------------------------------------------------------------
// tpm_checker
// port-level checks of the trend pattern matcher
// ----------------------------------------------------------------------------
`default_nettype none

`include "trend_pattern_matcher_top_defines.svh"

module tpm_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    // stalled result holds
    `TPM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // input only stalls behind a blocked result
    `TPM_ASSERT_IMP(a_stall_cause, clk, rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

    // a new result follows an accepted item through the pending stage and output register
    `TPM_ASSERT_IMP(a_latency, clk, rst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))

    // a match always leaves a nonzero count
    `TPM_ASSERT_IMP(a_match_count, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata != 32'd0)

endmodule

bind trend_pattern_matcher_top tpm_checker u_tpm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the trend pattern matcher
//
// A short table of directed samples covers the first sample after reset, the
// signed extremes, sequence restarts, an empty pattern and a fall step coded
// as 3. Then random phases, each under its own pattern length and code
// (0, 16, 17 and 31 among the lengths). Most samples in these phases follow
// the configured trend so that windows really match, and the rest are noise.
// A bench model of the step window and match counter predicts every result
// item the table does not give; the result stream is checked in order.
// ----------------------------------------------------------------------------

module tb;
    import tpm_pkg::*;

    localparam int HIST_DEPTH  = 16;
    localparam int STALL_LIMIT = 1000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 54;
    localparam int DIR_ROWS    = 20;

    localparam logic [PADDR_W-1:0] ADDR_LENGTH = {REG_PATTERN_LENGTH, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_CODE   = {REG_PATTERN_CODE, 2'b00};

    typedef struct packed {
        logic        window_match;
        logic [31:0] match_count;
    } window_result_t;

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_LENGTH, ROW_CODE} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] value;
        logic        start;
        logic        typed;
        logic        exp_match;
        logic [31:0] exp_count;
    } stim_row_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata = '0;   // [31:0] sample
    logic               s_axis_tuser = 1'b0; // [0] sequence_start
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [31:0]        m_axis_tdata;        // [31:0] match_count
    logic               m_axis_tuser;        // [0] window_match

    trend_pattern_matcher_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predictor state
    logic [4:0]  cfg_len = 5'd1;
    logic [31:0] cfg_code = '0;
    logic [31:0] last_sample = '0;
    bit          have_last = 1'b0;
    logic [1:0]  step_hist [HIST_DEPTH];
    int unsigned steps_held = 0;
    logic [31:0] seq_count = '0;

    window_result_t expected_windows [$];
    int  mismatch_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  window_hits = 0;
    bit  calm = 1'b0;
    bit  long_stall_done = 1'b0;
    int  src_run = 0;
    int  src_burst = 0;

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_SAMPLE, 32'd5,        1'b0, 1'b1, 1'b0, 32'd0},
        '{ROW_SAMPLE, 32'd5,        1'b0, 1'b1, 1'b1, 32'd1},
        '{ROW_SAMPLE, 32'd6,        1'b0, 1'b1, 1'b0, 32'd1},
        '{ROW_SAMPLE, 32'h7FFFFFFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_SAMPLE, 32'h80000000, 1'b0, 1'b1, 1'b0, 32'd1},
        '{ROW_SAMPLE, 32'h80000000, 1'b0, 1'b1, 1'b1, 32'd2},
        '{ROW_SAMPLE, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b0, 32'd0},
        '{ROW_SAMPLE, 32'd0,        1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_LENGTH, 32'd0,        1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_SAMPLE, 32'h12345678, 1'b0, 1'b1, 1'b1, 32'd1},
        '{ROW_SAMPLE, 32'hA5A5A5A5, 1'b1, 1'b1, 1'b1, 32'd1},
        '{ROW_CODE,   32'h0000000D, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_LENGTH, 32'd3,        1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_SAMPLE, 32'd10,       1'b1, 1'b1, 1'b0, 32'd0},
        '{ROW_SAMPLE, 32'd20,       1'b0, 1'b1, 1'b0, 32'd0},
        '{ROW_SAMPLE, 32'd15,       1'b0, 1'b1, 1'b0, 32'd0},
        '{ROW_SAMPLE, 32'd15,       1'b0, 1'b1, 1'b1, 32'd1},
        '{ROW_SAMPLE, 32'h80000000, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_SAMPLE, 32'h7FFFFFFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{ROW_SAMPLE, 32'h7FFFFFFF, 1'b0, 1'b0, 1'b0, 32'd0}
    };

    logic [4:0]  phase_len  [PHASES] = '{5'd1, 5'd2, 5'd16, 5'd31, 5'd17,
                                         5'd0, 5'd5, 5'd8, 5'd16, 5'd3};
    logic [31:0] phase_code [PHASES] = '{32'h0, 32'h0, 32'hFFFFFFFF, 32'h0, 32'h0,
                                         32'h0, 32'h0, 32'h0, 32'h00000000, 32'h0};
    bit          code_rand  [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1,
                                         1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        foreach (step_hist[i])
            step_hist[i] = STEP_EQUAL;
    end

    function automatic bit take_idle(inout int run_left, inout int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 1'b1;
        end
        if (run_left > 0)
        begin
            run_left--;
            return 1'b0;
        end
        burst_left = $urandom_range(0, 10);
        run_left = $urandom_range(0, 40);
        return 1'b1;
    endfunction

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    task automatic predict_window(input logic [31:0] smp, input logic st,
                                  output window_result_t res);
        int         eff;
        bit         hit;
        logic [1:0] want;
        if (st)
        begin
            last_sample = '0;
            have_last = 1'b0;
            steps_held = 0;
            seq_count = '0;
            foreach (step_hist[i])
                step_hist[i] = STEP_EQUAL;
        end
        if (have_last)
        begin
            for (int i = HIST_DEPTH - 1; i > 0; i--)
                step_hist[i] = step_hist[i - 1];
            if ($signed(smp) > $signed(last_sample))
                step_hist[0] = STEP_RISE;
            else if (smp == last_sample)
                step_hist[0] = STEP_EQUAL;
            else
                step_hist[0] = STEP_FALL;
            if (steps_held < HIST_DEPTH)
                steps_held++;
        end
        last_sample = smp;
        have_last = 1'b1;
        eff = (cfg_len > HIST_DEPTH) ? HIST_DEPTH : int'(cfg_len);
        hit = (steps_held >= eff);
        for (int j = 0; j < eff; j++)
        begin
            want = cfg_code[2*j +: 2];
            if (want == STEP_FALL2)
                want = STEP_FALL;
            if (step_hist[eff - 1 - j] != want)
                hit = 1'b0;
        end
        if (hit && seq_count != 32'hFFFFFFFF)
            seq_count++;
        res.window_match = hit;
        res.match_count = seq_count;
    endtask

    // offer one item and hold it until accepted
    task automatic push_sample(input logic [31:0] smp, input logic st, input logic typed,
                               input window_result_t typed_res);
        window_result_t res;
        while (!calm && take_idle(src_run, src_burst))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= smp;
        s_axis_tuser <= st;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_window(smp, st, res);
        expected_windows.insert(expected_windows.size(), typed ? typed_res : res);
        items_sent++;
    endtask

    // drop valid and let the block drain before a register write
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_windows.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_LENGTH)
            cfg_len = val[4:0];
        else
            cfg_code = val;
        @(posedge clk);
    endtask

    // result checker with random backpressure and one long hold
    initial
    begin : result_sink
        int             snk_run;
        int             snk_burst;
        int             hold_left;
        window_result_t want;
        snk_run = 0;
        snk_burst = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (m_axis_tuser === 1'b1)
                    window_hits++;
                if (expected_windows.size() == 0)
                    flag_error($sformatf("unexpected result: match %b count %0d",
                                         m_axis_tuser, m_axis_tdata));
                else
                begin
                    want = expected_windows.pop_front();
                    if (m_axis_tuser !== want.window_match ||
                        m_axis_tdata !== want.match_count)
                        flag_error($sformatf(
                            "result %0d: expected match %b count %0d, got match %b count %0d",
                            results_seen, want.window_match, want.match_count,
                            m_axis_tuser, m_axis_tdata));
                end
            end
            if (!long_stall_done && results_seen >= 200 && s_axis_tvalid)
            begin
                long_stall_done = 1'b1;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= !(!calm && take_idle(snk_run, snk_burst));
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results pending",
                         quiet, expected_windows.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        window_result_t typed_res;
        logic [31:0]    code;
        logic [31:0]    smp;
        logic [31:0]    gen_last;
        logic [1:0]     cls;
        logic           st;
        longint         delta;
        longint         nxt;
        int             eff;
        int             pos;
        int             mode;
        gen_last = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            case (dir_rows[r].kind)
                ROW_SAMPLE:
                begin
                    typed_res.window_match = dir_rows[r].exp_match;
                    typed_res.match_count = dir_rows[r].exp_count;
                    push_sample(dir_rows[r].value, dir_rows[r].start, dir_rows[r].typed,
                                typed_res);
                end
                ROW_LENGTH:
                begin
                    settle();
                    write_reg(ADDR_LENGTH, dir_rows[r].value);
                end
                default:
                begin
                    settle();
                    write_reg(ADDR_CODE, dir_rows[r].value);
                end
            endcase
        end
        gen_last = last_sample;

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            code = code_rand[p] ? $urandom : phase_code[p];
            write_reg(ADDR_LENGTH, {27'd0, phase_len[p]});
            write_reg(ADDR_CODE, code);
            if (p == PHASES - 1)
                calm = 1'b1;
            eff = (phase_len[p] > HIST_DEPTH) ? HIST_DEPTH : int'(phase_len[p]);
            pos = 0;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                st = (k == 0) || ($urandom_range(0, 24) == 0);
                if (st)
                    pos = 0;
                mode = $urandom_range(0, 9);
                if (st || mode == 0)
                    smp = $urandom;
                else
                begin
                    // mostly follow the pattern, otherwise a random trend
                    if (mode <= 7 && eff > 0)
                    begin
                        cls = code[2*pos +: 2];
                        if (cls == STEP_FALL2)
                            cls = STEP_FALL;
                        pos = (pos + 1) % eff;
                    end
                    else
                        cls = 2'($urandom_range(0, 2));
                    if ($urandom_range(0, 3) == 0)
                        delta = longint'($urandom) + 1;
                    else
                        delta = longint'($urandom_range(1, 64));
                    nxt = longint'($signed(gen_last));
                    if (cls == STEP_RISE)
                        nxt = nxt + delta;
                    else if (cls == STEP_FALL)
                        nxt = nxt - delta;
                    if (nxt > 64'sd2147483647)
                        nxt = 64'sd2147483647;
                    if (nxt < -64'sd2147483648)
                        nxt = -64'sd2147483648;
                    smp = nxt[31:0];
                end
                push_sample(smp, st, 1'b0, '0);
                gen_last = smp;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_windows.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("run: %0d samples over %0d register settings, %0d results checked",
                 items_sent, PHASES + 3, results_seen);
        $display("run: %0d matching windows, long output stall %s",
                 window_hits, long_stall_done ? "applied" : "not reached");
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
